[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation codes, result width, and the command and status groups that
// connect the controller to the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Width of a reduced result that counts as fitting.
  localparam int unsigned WIDTH = 32;

  // Width of the unreduced intermediates (products and their sums).
  localparam int unsigned MAG_W = 64;

  // Number of quotient bits produced by the serial divider.
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned DCNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Which of the four products the shared multiplier forms.
  typedef enum logic [1:0] {
    MSEL_LN_RD = 2'd0,
    MSEL_RN_LD = 2'd1,
    MSEL_LN_RN = 2'd2,
    MSEL_LD_RD = 2'd3
  } msel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;       // capture a new request
    logic  mul;        // form one product
    msel_e mul_sel;    // which product
    logic  combine;    // numerator, denominator and compare flags
    logic  sign;       // move the sign to the numerator
    logic  gcd_init;   // seed the gcd unit
    logic  gcd_step;   // one gcd step, or capture the gcd when done
    logic  div_load;   // start dividing the numerator magnitude
    logic  div_step;   // one quotient bit
    logic  div_swap;   // keep numerator quotient, start on the denominator
    logic  div_store;  // keep the denominator quotient
    logic  finish;     // format the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gcd_done;  // one gcd operand has reached zero
    logic special;   // division by zero or zero denominator: skip reduction
  } status_t;

endpackage

[src/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through multiply, combine, sign, gcd and two serial
// divisions, and owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_SIGN,
    S_GINIT,
    S_GCD,
    S_DLOAD,
    S_DIVN,
    S_DSWAP,
    S_DIVD,
    S_DSTORE,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [1:0]          mcnt_q, mcnt_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic                ovalid_q, ovalid_d;
  logic                can_load;

  // The output register may be refilled when empty or being emptied.
  assign can_load = !ovalid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d  = state_q;
    mcnt_d   = mcnt_q;
    dcnt_d   = dcnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.mul_sel = msel_e'(mcnt_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mcnt_d     = 2'd0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        mcnt_d    = mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_d       = S_SIGN;
      end
      S_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = S_GINIT;
      end
      S_GINIT: begin
        // The special flag is valid once the sign step has run.
        if (status_i.special) begin
          state_d = S_FIN;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (status_i.gcd_done) begin
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        dcnt_d         = '0;
        state_d        = S_DIVN;
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DSWAP;
        end
      end
      S_DSWAP: begin
        cmd_o.div_swap = 1'b1;
        dcnt_d         = '0;
        state_d        = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        if (can_load) begin
          cmd_o.finish = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mcnt_q   <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mcnt_q   <= mcnt_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

[src/rau_dp.sv]
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Shared multiplier, combine and sign logic, a binary gcd unit and a
// restoring divider that reduces numerator and denominator in turn.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
(
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] left_numerator_i,
  input  logic [30:0]        left_denominator_i,
  input  logic signed [31:0] right_numerator_i,
  input  logic [30:0]        right_denominator_i,
  output logic signed [31:0] result_numerator_o,
  output logic [30:0]        result_denominator_o,
  output logic               less_flag_o,
  output logic               equal_flag_o,
  output logic               zero_divide_flag_o,
  output logic               overflow_flag_o
);

  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (WIDTH - 1);
  localparam int unsigned K_W = $clog2(MAG_W);

  // Captured request.
  op_e                op_q;
  logic signed [31:0] ln_q, rn_q;
  logic [30:0]        ld_q, rd_q;

  // Products and intermediates.
  logic signed [MAG_W-1:0] pl_q, pr_q, pn_q, pd_q;
  logic signed [MAG_W-1:0] num_q, den_q;
  logic                    less_q, equal_q, zdiv_q;
  logic [MAG_W-1:0]        mag_q, dmag_q;
  logic                    neg_q, special_q;

  // Gcd and divider state.
  logic [MAG_W-1:0] ga_q, gb_q, g_q;
  logic [K_W-1:0]   gk_q;
  logic [MAG_W-1:0] dq_q, rem_q;

  // Output register.
  logic signed [31:0] res_num_q;
  logic [30:0]        res_den_q;
  logic               res_less_q, res_equal_q, res_zdiv_q, res_ovf_q;

  // Shared multiplier operands.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;

  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_LN_RD: begin
        ma = {ln_q[31], ln_q};
        mb = {2'b00, rd_q};
      end
      MSEL_RN_LD: begin
        ma = {rn_q[31], rn_q};
        mb = {2'b00, ld_q};
      end
      MSEL_LN_RN: begin
        ma = {ln_q[31], ln_q};
        mb = {rn_q[31], rn_q};
      end
      default: begin
        ma = {2'b00, ld_q};
        mb = {2'b00, rd_q};
      end
    endcase
    mprod = ma * mb;
  end

  // Numerator, denominator and compare terms for the combine step.
  logic signed [MAG_W-1:0] num_c, den_c;
  always_comb begin
    case (op_q)
      OP_ADD: begin
        num_c = pl_q + pr_q;
        den_c = pd_q;
      end
      OP_SUB: begin
        num_c = pl_q - pr_q;
        den_c = pd_q;
      end
      OP_MUL: begin
        num_c = pn_q;
        den_c = pd_q;
      end
      default: begin
        num_c = pl_q;
        den_c = pr_q;
      end
    endcase
  end

  // Sign normalization.
  logic signed [MAG_W-1:0] num_s, den_s;
  assign num_s = den_q[MAG_W-1] ? -num_q : num_q;
  assign den_s = den_q[MAG_W-1] ? -den_q : den_q;

  // Gcd completes when either operand reaches zero.
  logic gdone;
  assign gdone = (ga_q == '0) || (gb_q == '0);

  // Restoring divider step.
  logic [MAG_W-1:0] rem_sh;
  logic             qbit;
  assign rem_sh = {rem_q[MAG_W-2:0], dq_q[MAG_W-1]};
  assign qbit   = (rem_sh >= g_q);

  // Output formatting.
  logic [MAG_W-1:0] sval;
  logic             ovf_c;
  assign sval  = neg_q ? (MAG_W'(0) - mag_q) : mag_q;
  assign ovf_c = (neg_q ? (mag_q > HALF) : (mag_q > HALF - 1'b1)) ||
                 (dmag_q > HALF - 1'b1);

  always_ff @(posedge clk_i) begin
    // Capture the request.
    if (cmd_i.load) begin
      op_q <= op_e'(operation_i);
      ln_q <= left_numerator_i;
      ld_q <= left_denominator_i;
      rn_q <= right_numerator_i;
      rd_q <= right_denominator_i;
    end
    // One product per cycle.
    if (cmd_i.mul) begin
      case (cmd_i.mul_sel)
        MSEL_LN_RD: pl_q <= MAG_W'(mprod);
        MSEL_RN_LD: pr_q <= MAG_W'(mprod);
        MSEL_LN_RN: pn_q <= MAG_W'(mprod);
        default:    pd_q <= MAG_W'(mprod);
      endcase
    end
    // Combine and compare.
    if (cmd_i.combine) begin
      num_q   <= num_c;
      den_q   <= den_c;
      less_q  <= (pl_q < pr_q);
      equal_q <= (pl_q == pr_q);
      zdiv_q  <= (op_q == OP_DIV) && (rn_q == '0);
    end
    // Sign to the numerator.
    if (cmd_i.sign) begin
      neg_q     <= num_s[MAG_W-1];
      mag_q     <= num_s[MAG_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
      dmag_q    <= MAG_W'(den_s);
      special_q <= zdiv_q || (den_s == '0);
    end
    // Binary gcd.
    if (cmd_i.gcd_init) begin
      ga_q <= mag_q;
      gb_q <= dmag_q;
      gk_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (gdone) begin
        g_q <= (ga_q | gb_q) << gk_q;
      end else if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + 1'b1;
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
    // Serial division by the gcd.
    if (cmd_i.div_load) begin
      dq_q  <= mag_q;
      rem_q <= '0;
    end else if (cmd_i.div_swap) begin
      mag_q <= dq_q;
      dq_q  <= dmag_q;
      rem_q <= '0;
    end else if (cmd_i.div_store) begin
      dmag_q <= dq_q;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? (rem_sh - g_q) : rem_sh;
      dq_q  <= {dq_q[MAG_W-2:0], qbit};
    end
    // Output register.
    if (cmd_i.finish) begin
      res_less_q  <= less_q;
      res_equal_q <= equal_q;
      res_zdiv_q  <= zdiv_q;
      if (special_q) begin
        res_num_q <= '0;
        res_den_q <= '0;
        res_ovf_q <= 1'b0;
      end else begin
        res_num_q <= 32'(signed'(sval[WIDTH-1:0]));
        res_den_q <= 31'(dmag_q[WIDTH-2:0]);
        res_ovf_q <= ovf_c;
      end
    end
  end

  assign status_o.gcd_done = gdone;
  assign status_o.special  = special_q;

  assign result_numerator_o   = res_num_q;
  assign result_denominator_o = res_den_q;
  assign less_flag_o          = res_less_q;
  assign equal_flag_o         = res_equal_q;
  assign zero_divide_flag_o   = res_zdiv_q;
  assign overflow_flag_o      = res_ovf_q;

endmodule

[src/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact add, subtract, multiply and divide of
// fractions with gcd reduction
// Usage:
//   Requests arrive on the s_axis channel: tuser[1:0] holds the operation,
//   tdata holds both operands. Results leave on the m_axis channel with the
//   reduced fraction in tdata and the status flags in tuser.
//   One request is worked on at a time. s_axis_tready is high only while
//   the sequencer is idle. After acceptance the sequencer forms its
//   products on the shared multiplier, runs combine, sign and setup, then
//   the binary gcd loop (one shift or subtract a cycle on 64-bit
//   magnitudes), then two restoring divisions, one quotient bit a cycle,
//   with divider load, swap and store steps and a final formatting step.
//   Division by zero and zero denominators skip the gcd and divisions and
//   go from setup straight to the formatting step.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver still stalls when the next result is ready,
//   the sequencer holds it until the register frees up.
//   Reset clears the sequencer and the output valid; a request in flight
//   and a result waiting in the output register are lost.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] left_numerator, [62:32] left_denominator,
  // [94:63] right_numerator, [125:95] right_denominator, [127:126] zero
  input  logic [127:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result_numerator, [62:32] result_denominator, [63] zero
  output logic [63:0]  m_axis_tdata,
  // [0] less_flag, [1] equal_flag, [2] zero_divide_flag, [3] overflow_flag
  output logic [3:0]   m_axis_tuser
);

  cmd_t               cmd;
  status_t            status;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               less_f, equal_f, zdiv_f, ovf_f;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  rau_dp u_dp (
    .clk_i                (clk_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .operation_i          (s_axis_tuser),
    .left_numerator_i     (s_axis_tdata[31:0]),
    .left_denominator_i   (s_axis_tdata[62:32]),
    .right_numerator_i    (s_axis_tdata[94:63]),
    .right_denominator_i  (s_axis_tdata[125:95]),
    .result_numerator_o   (res_num),
    .result_denominator_o (res_den),
    .less_flag_o          (less_f),
    .equal_flag_o         (equal_f),
    .zero_divide_flag_o   (zdiv_f),
    .overflow_flag_o      (ovf_f)
  );

  // Pack the result.
  assign m_axis_tdata = {1'b0, res_den, res_num};
  assign m_axis_tuser = {ovf_f, zdiv_f, equal_f, less_f};

  // A division by zero reports a zero fraction and no overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |->
      (m_axis_tdata[62:0] == '0 && !m_axis_tuser[3]))
    else $error("zero divide result not cleared");

  // A result that fits with a nonzero numerator has a nonzero denominator unless it is a zero divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[3] && !m_axis_tuser[2] &&
     m_axis_tdata[31:0] != '0) |-> (m_axis_tdata[62:32] != '0))
    else $error("reduced result has zero denominator");

  // Accepting a request makes the sequencer busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer accepted a request without going busy");

  // Less and equal are never reported together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("less and equal both set");

endmodule

[bench/rational_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// Sends directed and random fraction pairs with every operation, predicts
// each reduced result and the compare flags, and checks every result in
// order, with random stalls on both sides in all but the last phase.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        less;
    logic        equal;
    logic        zdiv;
    logic        ovf;
  } frac_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  frac_result_t expected_q[$];
  int unsigned  error_count = 0;
  int unsigned  result_count = 0;
  int unsigned  request_count = 0;
  bit           sender_gaps = 1'b1;
  bit           receiver_gaps = 1'b1;
  int unsigned  hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  rational_arithmetic_unit u_top (.*);

  // Greatest common divisor on 64-bit magnitudes.
  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Exact rational result and compare flags for one request.
  function automatic frac_result_t reduce_fraction(op_e op, logic signed [31:0] ln,
      logic [30:0] ld, logic signed [31:0] rn, logic [30:0] rd);
    frac_result_t r;
    logic signed [63:0] cl, cr, num, den;
    logic [63:0] mag, dmag, g, half, wmask, nbits;
    logic neg;
    cl = 64'(ln) * $signed({33'd0, rd});
    cr = 64'(rn) * $signed({33'd0, ld});
    r = '0;
    r.zdiv = 1'b0;
    case (op)
      OP_ADD: begin num = cl + cr; den = $signed({33'd0, ld}) * $signed({33'd0, rd}); end
      OP_SUB: begin num = cl - cr; den = $signed({33'd0, ld}) * $signed({33'd0, rd}); end
      OP_MUL: begin num = 64'(ln) * 64'(rn); den = $signed({33'd0, ld}) * $signed({33'd0, rd}); end
      default: begin num = cl; den = cr; r.zdiv = (rn == 0); end
    endcase
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = num < 0;
    mag = neg ? -num : num;
    dmag = den;
    half = 64'd1 << (WIDTH - 1);
    wmask = (64'd1 << WIDTH) - 64'd1;
    if (!(r.zdiv || dmag == 0)) begin
      if (mag == 0) begin
        dmag = 1;
      end else begin
        g = gcd64(mag, dmag);
        mag = mag / g;
        dmag = dmag / g;
      end
      r.ovf = neg ? (mag > half) : (mag > half - 1);
      if (dmag > half - 1) r.ovf = 1'b1;
      // Low WIDTH bits, sign-extended from the top one of them.
      nbits = (neg ? -mag : mag) & wmask;
      if ((nbits & half) != 0) nbits = nbits | ~wmask;
      r.num = nbits[31:0];
      r.den = 31'(dmag & (half - 1));
    end
    r.less = cl < cr;
    r.equal = cl == cr;
    return r;
  endfunction

  // Send one request and record its expected result.
  task automatic send_request(op_e op, logic [31:0] ln, logic [30:0] ld,
      logic [31:0] rn, logic [30:0] rd);
    int unsigned gap;
    if (sender_gaps && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {2'b00, rd, rn, ld, ln};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(reduce_fraction(op, ln, ld, rn, rd));
    request_count++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(4))
      0: return 32'($signed($urandom_range(20)) - 10);
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0: return 31'($urandom_range(12, 1));
      1: return $urandom_range(1) ? 31'h7fff_ffff : 31'd1;
      2: return 31'($urandom_range(1000, 1));
      default: return 31'($urandom_range(32'h7fff_ffff, 1));
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Extremes, every operation, zero results, division by zero and overflow.
  task automatic test_directed();
    op_e op;
    for (int i = 0; i < 4; i++) begin
      op = op_e'(i);
      send_request(op, 32'd1, 31'd2, 32'd1, 31'd3);
      send_request(op, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
      send_request(op, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
      send_request(op, 32'd0, 31'd5, 32'd0, 31'h7fff_ffff);
      send_request(op, 32'hffff_fffd, 31'd6, 32'd2, 31'd4);
    end
    send_request(OP_DIV, 32'd7, 31'd3, 32'd0, 31'd9);
    send_request(OP_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
    send_request(OP_MUL, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
    wait_drained();
  endtask

  // Random requests, with random gaps on each side while its gap flag is set.
  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_request(op_e'($urandom_range(3)), rand_num(), rand_den(), rand_num(), rand_den());
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_cycles = 800;
    test_random(12);
    wait_drained();
  endtask

  // Receiver process: random stalls and a long hold when asked.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (receiver_gaps && $urandom_range(7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    frac_result_t exp_r, act_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_r = {m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tuser[0],
               m_axis_tuser[1], m_axis_tuser[2], m_axis_tuser[3]};
      result_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act_r);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.num !== act_r.num || exp_r.den !== act_r.den ||
            exp_r.less !== act_r.less || exp_r.equal !== act_r.equal ||
            exp_r.zdiv !== act_r.zdiv || exp_r.ovf !== act_r.ovf) begin
          $display("%0t: mismatch expected num %h den %h flags %b%b%b%b",
                   $time, exp_r.num, exp_r.den, exp_r.less, exp_r.equal,
                   exp_r.zdiv, exp_r.ovf);
          $display("%0t:          actual   num %h den %h flags %b%b%b%b",
                   $time, act_r.num, act_r.den, act_r.less, act_r.equal,
                   act_r.zdiv, act_r.ovf);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1000);
    // Sender pauses until every result is back.
    wait_drained();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random(160);
    wait_drained();
    repeat (400) @(negedge clk_i);
    $display("Sent %0d requests over all four operations, checked %0d results.",
             request_count, result_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
